[hw/rtl/sara_pkg.sv]
// Shared types and constants for the shelf atlas region allocator.
// Depends on nothing; imported by the slot memory and the top level.
package sara_pkg;

	localparam int MAX_GROUPS     = 16;
	localparam int MAX_ATLASES    = 8;
	localparam int COORD_BITS     = 14;
	localparam int GROUP_BITS     = 4;
	localparam int POS_BITS       = COORD_BITS - 1;
	localparam int SLOT_IDX_BITS  = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
	localparam int COUNT_BITS     = $clog2(MAX_ATLASES + 1);
	localparam int SLOT_COUNT     = MAX_GROUPS * MAX_ATLASES;
	localparam int SLOT_ADDR_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [COORD_BITS-1:0] SIDE_LIMIT = COORD_BITS'(1 << (COORD_BITS - 1));
	localparam logic [COORD_BITS-1:0] SIDE_RESET = COORD_BITS'(1024);

	typedef logic [COORD_BITS-1:0]     coord_t;
	typedef logic [SLOT_ADDR_BITS-1:0] slot_addr_t;
	typedef logic [COUNT_BITS-1:0]     count_t;

	// One atlas: its side and its packing cursor.
	typedef struct packed {
		coord_t size;
		coord_t cur_x;
		coord_t cur_y;
		coord_t shelf_h;
	} slot_t;

	// Write port of the slot memory.
	typedef struct packed {
		logic       en;
		slot_addr_t addr;
		slot_t      data;
	} slot_wr_t;

	typedef enum logic [1:0] {
		STAT_GRANTED = 2'd0,
		STAT_TOO_BIG = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DECIDE,
		S_PUSH
	} state_t;

endpackage

[hw/rtl/sara_slot_ram.sv]
// Slot memory: one entry per (group, atlas), one write and one registered read.
// Depends on sara_pkg for the slot word and address types.
module sara_slot_ram
	import sara_pkg::*;
(
	input  logic       clk,
	input  slot_wr_t   wr,
	input  slot_addr_t rd_addr,
	output slot_t      rd_data
);

	slot_t mem [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/shelf_atlas_region_allocator_top.sv]
// Top level of the shelf atlas region allocator.
// Depends on sara_pkg and instantiates sara_slot_ram.
//
// Each request word (group, width, height) is placed first-fit over the
// group's open atlases using shelf packing; if none takes it, a new square
// atlas of side atlas_side is opened. One request is in work at a time. A
// request is taken in (S_IDLE), then one atlas is tried per cycle (S_EVAL; the
// slot memory has one registered read port, addressed in the state before),
// S_DECIDE follows when no open atlas fits, and S_PUSH hands the result to the
// output register once it is free or being emptied.
// The output register holds a finished result while the next request is
// taken in. Atlas state lives in a 128-entry slot memory with no reset value;
// only entries of opened atlases are used, so no clearing pass is needed.
// The per-group atlas counts are flip-flops cleared by reset. A write of zero
// to atlas_side is ignored; larger values than 8192 saturate to 8192.
module shelf_atlas_region_allocator_top
	import sara_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_wr_en,
	input  logic [COORD_BITS-1:0] cfg_wr_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [GROUP_BITS-1:0] group_id,
	input  logic [COORD_BITS-1:0] req_width,
	input  logic [COORD_BITS-1:0] req_height,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [2:0]            atlas_index,
	output logic [POS_BITS-1:0]   pos_x,
	output logic [POS_BITS-1:0]   pos_y,
	output logic                  opened_new
);

	state_t state_q, state_d;

	coord_t                side_q;
	count_t                cnt_q [MAX_GROUPS];

	// Request held for the whole search
	logic [GROUP_BITS-1:0] grp_q;
	coord_t                w_q, h_q;
	count_t                n_q;
	count_t                idx_q, idx_d;

	// Finished result waiting for the output register
	status_t               res_stat_q, res_stat_d;
	logic [2:0]            res_idx_q, res_idx_d;
	coord_t                res_x_q, res_x_d;
	coord_t                res_y_q, res_y_d;
	logic                  res_new_q, res_new_d;
	logic                  res_load;

	// Output register
	logic                  out_valid_q;
	status_t               out_stat_q;
	logic [2:0]            out_idx_q;
	logic [POS_BITS-1:0]   out_x_q, out_y_q;
	logic                  out_new_q;
	logic                  out_load;

	logic                  accept;
	logic                  open_new;

	slot_wr_t              wr;
	slot_addr_t            rd_addr;
	slot_t                 rd_data;

	// Placement arithmetic on the slot just read
	logic                  fits_dims, move, ok;
	logic [COORD_BITS:0]   sum_xw, sum_yh;
	logic [COORD_BITS+1:0] sum_ysh_h;
	coord_t                cy_moved, cx1, sh1;
	slot_t                 wb;

	function automatic slot_addr_t slot_addr(logic [GROUP_BITS-1:0] g, count_t i);
		return SLOT_ADDR_BITS'(g * MAX_ATLASES + i[SLOT_IDX_BITS-1:0]);
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// Configuration: drop zero, saturate oversized sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (cfg_wr_en && cfg_wr_data != '0) begin
			side_q <= (cfg_wr_data > SIDE_LIMIT) ? SIDE_LIMIT : cfg_wr_data;
		end
	end

	sara_slot_ram u_slot_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Shelf placement: the width test, the height test on the current row and
	// the height test on a fresh row are worked out side by side.
	always_comb begin
		fits_dims = (w_q <= rd_data.size) && (h_q <= rd_data.size);
		sum_xw    = {1'b0, rd_data.cur_x} + {1'b0, w_q};
		sum_yh    = {1'b0, rd_data.cur_y} + {1'b0, h_q};
		sum_ysh_h = {2'b0, rd_data.cur_y} + {2'b0, rd_data.shelf_h} + {2'b0, h_q};
		cy_moved  = rd_data.cur_y + rd_data.shelf_h;
		move      = fits_dims && (sum_xw > {1'b0, rd_data.size});
		if (move) begin
			ok = fits_dims && (sum_ysh_h <= {2'b0, rd_data.size});
		end else begin
			ok = fits_dims && (sum_yh <= {1'b0, rd_data.size});
		end
		cx1 = move ? '0 : rd_data.cur_x;
		sh1 = move ? '0 : rd_data.shelf_h;

		wb.size    = rd_data.size;
		wb.cur_y   = move ? cy_moved : rd_data.cur_y;
		if (ok) begin
			wb.cur_x   = move ? w_q : sum_xw[COORD_BITS-1:0];
			wb.shelf_h = (h_q > sh1) ? h_q : sh1;
		end else begin
			wb.cur_x   = cx1;
			wb.shelf_h = sh1;
		end
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		res_load   = 1'b0;
		res_stat_d = STAT_GRANTED;
		res_idx_d  = '0;
		res_x_d    = '0;
		res_y_d    = '0;
		res_new_d  = 1'b0;
		open_new   = 1'b0;
		out_load   = 1'b0;
		wr.en      = 1'b0;
		wr.addr    = slot_addr(grp_q, idx_q);
		wr.data    = wb;
		rd_addr    = slot_addr(group_id, '0);

		case (state_q)
			S_IDLE: begin
				// Read the first atlas of the group as the request is taken
				if (accept) begin
					idx_d   = '0;
					state_d = (cnt_q[group_id] == '0) ? S_DECIDE : S_EVAL;
				end
			end
			S_EVAL: begin
				rd_addr = slot_addr(grp_q, idx_q + count_t'(1));
				wr.en   = move || ok;
				if (ok) begin
					res_load  = 1'b1;
					res_idx_d = idx_q[2:0];
					res_x_d   = cx1;
					res_y_d   = wb.cur_y;
					state_d   = S_PUSH;
				end else if (idx_q + count_t'(1) < n_q) begin
					idx_d = idx_q + count_t'(1);
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				res_load = 1'b1;
				state_d  = S_PUSH;
				if (w_q > side_q || h_q > side_q) begin
					res_stat_d = STAT_TOO_BIG;
				end else if (n_q >= count_t'(MAX_ATLASES)) begin
					res_stat_d = STAT_FULL;
				end else begin
					// Open a new atlas with the region at its top-left corner
					open_new        = 1'b1;
					res_idx_d       = n_q[2:0];
					res_new_d       = 1'b1;
					wr.en           = 1'b1;
					wr.addr         = slot_addr(grp_q, n_q);
					wr.data.size    = side_q;
					wr.data.cur_x   = w_q;
					wr.data.cur_y   = '0;
					wr.data.shelf_h = h_q;
				end
			end
			S_PUSH: begin
				// Hand over once the output register is free or being emptied
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int g = 0; g < MAX_GROUPS; g++) begin
				cnt_q[g] <= '0;
			end
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (open_new) begin
				cnt_q[grp_q] <= n_q + count_t'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			grp_q <= group_id;
			w_q   <= req_width;
			h_q   <= req_height;
			n_q   <= cnt_q[group_id];
		end
		if (res_load) begin
			res_stat_q <= res_stat_d;
			res_idx_q  <= res_idx_d;
			res_x_q    <= res_x_d;
			res_y_q    <= res_y_d;
			res_new_q  <= res_new_d;
		end
		if (out_load) begin
			out_stat_q <= res_stat_q;
			out_idx_q  <= res_idx_q;
			out_x_q    <= res_x_q[POS_BITS-1:0];
			out_y_q    <= res_y_q[POS_BITS-1:0];
			out_new_q  <= res_new_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_stat_q;
	assign atlas_index = out_idx_q;
	assign pos_x       = out_x_q;
	assign pos_y       = out_y_q;
	assign opened_new  = out_new_q;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the shelf atlas region allocator top level.
// Depends on sara_pkg and shelf_atlas_region_allocator_top; drives directed and random words.
module testbench
	import sara_pkg::*;
();

	// Cycle budget: about 1.8k words, plus long idle and stall runs.
	localparam int CYCLE_LIMIT = 600_000;
	// Cycles to let pass once the last result has come, before a register write or the end.
	localparam int SETTLE_CYCLES = MAX_ATLASES + 3;
	localparam int RANDOM_WORDS = 220;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	// One result word as the block presents it.
	typedef struct packed {
		status_t             st;
		logic [2:0]          idx;
		logic [POS_BITS-1:0] x;
		logic [POS_BITS-1:0] y;
		logic                opened;
	} region_t;

	// One row of the directed table: a request, or a write of atlas_side.
	typedef struct packed {
		row_kind_t             kind;
		logic [COORD_BITS-1:0] side_val;
		logic [GROUP_BITS-1:0] g;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
		logic                  typed;
		region_t               want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [COORD_BITS-1:0] cfg_wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [GROUP_BITS-1:0] group_id = '0;
	logic [COORD_BITS-1:0] req_width = '0;
	logic [COORD_BITS-1:0] req_height = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            status;
	logic [2:0]            atlas_index;
	logic [POS_BITS-1:0]   pos_x;
	logic [POS_BITS-1:0]   pos_y;
	logic                  opened_new;

	// Typed expectation travelling alongside the request word it belongs to.
	logic                  row_typed = 1'b0;
	region_t               row_want;

	// Predicted allocator state: side register, open atlases per group, and per-slot cursors.
	int                    side_now = SIDE_RESET;
	int                    open_count [MAX_GROUPS];
	int                    atlas_len [SLOT_COUNT];
	int                    shelf_x [SLOT_COUNT];
	int                    shelf_y [SLOT_COUNT];
	int                    shelf_h [SLOT_COUNT];

	region_t               region_q [$];
	plan_row_t             plan [$];

	int                    send_idle_pct = 0;
	int                    stall_pct = 0;
	int                    cycles = 0;
	int                    mismatches = 0;
	int                    words_sent = 0;
	int                    granted_cnt = 0;
	int                    opened_cnt = 0;
	int                    too_big_cnt = 0;
	int                    full_cnt = 0;

	shelf_atlas_region_allocator_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.group_id    (group_id),
		.req_width   (req_width),
		.req_height  (req_height),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.atlas_index (atlas_index),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.opened_new  (opened_new)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Place one request first-fit over the group's atlases and advance the predicted state.
	// A shelf move in an atlas that then refuses the height is kept.
	function automatic region_t place_region(input logic [GROUP_BITS-1:0] g,
			input logic [COORD_BITS-1:0] w_in, input logic [COORD_BITS-1:0] h_in);
		region_t r;
		int      w;
		int      h;
		int      n;
		int      s;
		int      i;
		bit      placed;
		r.st = STAT_GRANTED;
		r.idx = '0;
		r.x = '0;
		r.y = '0;
		r.opened = 1'b0;
		w = int'(w_in);
		h = int'(h_in);
		n = open_count[g];
		placed = 1'b0;
		for (i = 0; i < n && !placed; i++) begin
			s = int'(g) * MAX_ATLASES + i;
			if (w <= atlas_len[s] && h <= atlas_len[s]) begin
				if (shelf_x[s] + w > atlas_len[s]) begin
					shelf_x[s] = 0;
					shelf_y[s] += shelf_h[s];
					shelf_h[s] = 0;
				end
				if (shelf_y[s] + h <= atlas_len[s]) begin
					r.idx = 3'(i);
					// A zero-sized region can sit at 8192; the port keeps the low 13 bits.
					r.x = POS_BITS'(shelf_x[s]);
					r.y = POS_BITS'(shelf_y[s]);
					shelf_x[s] += w;
					if (h > shelf_h[s])
						shelf_h[s] = h;
					placed = 1'b1;
				end
			end
		end
		if (!placed) begin
			// Too large wins over a full group; neither opens an atlas.
			if (w > side_now || h > side_now) begin
				r.st = STAT_TOO_BIG;
			end else if (n >= MAX_ATLASES) begin
				r.st = STAT_FULL;
			end else begin
				s = int'(g) * MAX_ATLASES + n;
				atlas_len[s] = side_now;
				shelf_x[s] = w;
				shelf_y[s] = 0;
				shelf_h[s] = h;
				open_count[g] = n + 1;
				r.idx = 3'(n);
				r.opened = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Watch both channels and the register port at every rising edge.
	always @(posedge clk) begin : watch_ports
		region_t want;
		region_t r;
		if (arst_n) begin
			// Drop a zero write; saturate anything above the side limit.
			if (cfg_wr_en && cfg_wr_data != '0)
				side_now = (cfg_wr_data > SIDE_LIMIT) ? int'(SIDE_LIMIT) : int'(cfg_wr_data);
			if (in_valid && !in_stall) begin
				r = place_region(group_id, req_width, req_height);
				// Hold the typed value where the table gives one; the state still advances.
				region_q.insert(region_q.size(), row_typed ? row_want : r);
			end
			if (out_valid && !out_stall) begin
				case (status)
					STAT_GRANTED: granted_cnt++;
					STAT_TOO_BIG: too_big_cnt++;
					default:      full_cnt++;
				endcase
				if (opened_new)
					opened_cnt++;
				if (region_q.size() == 0) begin
					$display("%0t: result word with nothing expected, status %0d", $time, status);
					mismatches++;
				end else begin
					want = region_q.pop_front();
					compare_field("status", int'(want.st), int'(status));
					compare_field("atlas_index", int'(want.idx), int'(atlas_index));
					compare_field("pos_x", int'(want.x), int'(pos_x));
					compare_field("pos_y", int'(want.y), int'(pos_y));
					compare_field("opened_new", int'(want.opened), int'(opened_new));
				end
			end
		end
	end

	// Receiver: stall at random at the rate of the current phase.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, region_q.size());
			$display("testbench failed");
			$finish;
		end
	end

	// Offer one request word and hold it until accepted. Called at a rising edge;
	// returns at the edge of acceptance with valid still high.
	task automatic send_word(input logic [GROUP_BITS-1:0] g, input logic [COORD_BITS-1:0] w,
			input logic [COORD_BITS-1:0] h, input logic typed, input region_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		group_id <= g;
		req_width <= w;
		req_height <= h;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// Lower valid, wait for every expected result, then let the block settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (region_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write atlas_side; the block is idle here.
	task automatic write_side(input logic [COORD_BITS-1:0] v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Append one row to the directed table; refusals have all other fields zero.
	task automatic add_row(input row_kind_t kind, input logic [COORD_BITS-1:0] v,
			input logic [GROUP_BITS-1:0] g, input logic [COORD_BITS-1:0] w,
			input logic [COORD_BITS-1:0] h, input logic typed, input status_t st,
			input logic opened);
		plan_row_t row;
		row.kind = kind;
		row.side_val = v;
		row.g = g;
		row.w = w;
		row.h = h;
		row.typed = typed;
		row.want.st = st;
		row.want.idx = '0;
		row.want.x = '0;
		row.want.y = '0;
		row.want.opened = opened;
		plan.insert(plan.size(), row);
	endtask

	task automatic add_req(input logic [GROUP_BITS-1:0] g, input logic [COORD_BITS-1:0] w,
			input logic [COORD_BITS-1:0] h);
		add_row(ROW_REQ, '0, g, w, h, 1'b0, STAT_GRANTED, 1'b0);
	endtask

	// Request with its result typed in.
	task automatic add_typed(input logic [GROUP_BITS-1:0] g, input logic [COORD_BITS-1:0] w,
			input logic [COORD_BITS-1:0] h, input status_t st, input logic opened);
		add_row(ROW_REQ, '0, g, w, h, 1'b1, st, opened);
	endtask

	task automatic add_cfg(input logic [COORD_BITS-1:0] v);
		add_row(ROW_CFG, v, '0, '0, '0, 1'b0, STAT_GRANTED, 1'b0);
	endtask

	initial begin : stimulus
		int                    side_plan [8];
		int                    j;
		int                    k;
		int                    pick;
		int                    lim;
		int                    focus;
		logic [GROUP_BITS-1:0] g;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
		logic [COORD_BITS-1:0] t;
		region_t               none;

		none.st = STAT_GRANTED;
		none.idx = '0;
		none.x = '0;
		none.y = '0;
		none.opened = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, side 1024 after reset.
		add_typed(4'd0, 14'd0, 14'd0, STAT_GRANTED, 1'b1);     // zero-sized first request
		add_req(4'd0, 14'd1024, 14'd1024);                      // exact fit beside it
		add_typed(4'd1, 14'd1025, 14'd1, STAT_TOO_BIG, 1'b0);
		add_typed(4'd1, 14'd16383, 14'd16383, STAT_TOO_BIG, 1'b0);
		add_typed(4'd2, 14'd8192, 14'd0, STAT_TOO_BIG, 1'b0);
		// Fill group 3 with eight full atlases.
		add_typed(4'd3, 14'd1024, 14'd1024, STAT_GRANTED, 1'b1);
		for (k = 0; k < MAX_ATLASES - 1; k++)
			add_req(4'd3, 14'd1024, 14'd1024);
		add_typed(4'd3, 14'd1, 14'd1, STAT_FULL, 1'b0);
		add_typed(4'd3, 14'd2000, 14'd1, STAT_TOO_BIG, 1'b0);   // too large beats full
		// Shelf moves, one kept after the height fails.
		add_req(4'd4, 14'd600, 14'd100);
		add_req(4'd4, 14'd600, 14'd50);
		add_req(4'd4, 14'd500, 14'd1000);
		add_req(4'd4, 14'd10, 14'd10);
		add_cfg(14'd0);                                         // ignored, side stays 1024
		add_req(4'd5, 14'd1024, 14'd1);
		add_cfg(14'd16383);                                     // saturates to 8192
		add_typed(4'd6, 14'd8192, 14'd8192, STAT_GRANTED, 1'b1);
		add_req(4'd6, 14'd1, 14'd1);
		add_req(4'd6, 14'd0, 14'd0);                            // lands on the 8192 row
		add_cfg(14'd1);                                         // old atlases keep their side
		add_req(4'd6, 14'd1, 14'd1);
		add_typed(4'd7, 14'd2, 14'd1, STAT_TOO_BIG, 1'b0);
		add_typed(4'd7, 14'd1, 14'd1, STAT_GRANTED, 1'b1);
		add_req(4'd7, 14'd0, 14'd0);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_side(plan[i].side_val);
			else
				send_word(plan[i].g, plan[i].w, plan[i].h, plan[i].typed, plan[i].want);
		end

		// Random part: four idling phases, two side settings each.
		side_plan = '{1024, 16383, 0, 200, 8192, 1, 1, 64};
		side_plan[6] = $urandom_range(8192, 1);
		for (j = 0; j < 8; j++) begin
			write_side(COORD_BITS'(side_plan[j]));
			case (j / 2)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 82; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 82; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			// Aim most words at two groups so their atlases fill and shelves move.
			focus = (2 * j + 8) % MAX_GROUPS;
			lim = side_now / 6;
			if (lim < 1)
				lim = 1;
			for (k = 0; k < RANDOM_WORDS; k++) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					if ($urandom_range(9) < 7)
						g = GROUP_BITS'(focus + $urandom_range(1));
					else
						g = GROUP_BITS'($urandom);
					w = COORD_BITS'($urandom_range(lim));
					h = COORD_BITS'($urandom_range(lim));
					if ($urandom_range(9) == 0)
						w = COORD_BITS'($urandom_range(side_now));
					if ($urandom_range(9) == 0)
						h = COORD_BITS'($urandom_range(side_now));
				end else if (pick < 90) begin
					// Sizes right at the side, either way of it.
					g = GROUP_BITS'($urandom);
					w = COORD_BITS'(side_now - 1 + $urandom_range(2));
					h = COORD_BITS'($urandom_range(lim));
					if ($urandom_range(1)) begin
						t = w;
						w = h;
						h = t;
					end
				end else begin
					g = GROUP_BITS'($urandom);
					w = COORD_BITS'($urandom);
					h = COORD_BITS'($urandom);
				end
				send_word(g, w, h, 1'b0, none);
			end
		end

		send_idle_pct = 0;
		stall_pct = 0;
		drain_results();
		$display("Sent %0d request words over 4 idling phases and 8 side settings.", words_sent);
		$display("Results: %0d granted (%0d opened an atlas), %0d too large, %0d group full.",
			granted_cnt, opened_cnt, too_big_cnt, full_cnt);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/sara_pkg.sv
hw/rtl/sara_slot_ram.sv
hw/rtl/shelf_atlas_region_allocator_top.sv
tb/sv/testbench.sv
